### rtl/ppc_pkg.sv
// Shared types, constants and command structs for the polygon plane clipper.
`default_nettype none
package ppc_pkg;
   localparam int MaxVertsDefault = 64;
   localparam int CoordW = 32;
   localparam int CountW = 8;
   localparam int TW = 17;
   localparam logic [1:0] KIND_KEPT  = 2'd0;
   localparam logic [1:0] KIND_ISECT = 2'd1;
   localparam logic [1:0] KIND_TERM  = 2'd2;
   localparam logic [1:0] CSR_NX = 2'd0;
   localparam logic [1:0] CSR_NY = 2'd1;
   localparam logic [1:0] CSR_NZ = 2'd2;
   localparam logic [1:0] CSR_OFS = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DOT_X, ST_DOT_Y, ST_DOT_Z, ST_DIST, ST_EDGE1,
      ST_DIV1, ST_MUL1, ST_EMIT_I1, ST_EMIT_K1, ST_EDGE2, ST_DIV2, ST_MUL2,
      ST_EMIT_I2, ST_EMIT_K2, ST_TERM, ST_COMMIT
   } state_type;

   // datapath operation selects
   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_DOT_X, OP_DOT_Y, OP_DOT_Z, OP_DIST,
      OP_DIV_START, OP_DIV_STEP, OP_MUL, OP_COMMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       edge2;     // closing edge: prev=cur, cur=first
      logic       emit;
      logic [1:0] kind;
      logic       emit_end;  // result carries polygon end
   } cmd_type;

   typedef struct packed {
      logic prev_in;
      logic cur_in;
      logic div_done;
      logic mul_done;
      logic is_last;
      logic first;
      logic out_busy;
      logic end_pending; // no further vertex emitted in this step
   } status_type;
endpackage
`default_nettype wire

### rtl/polygon_plane_clip_core.sv
// Top level of the single-plane polygon clipper.
`default_nettype none
// Clips a polygon, one vertex per word, against the plane n.v + offset and
// keeps the negative side. One vertex is worked at a time and req_tready is
// high only while the core is idle. A vertex is worked as a dot product,
// the distance, the first edge and, for the last vertex, the closing edge;
// each intersection runs the radix-2 divider for t, one quotient bit a
// cycle, then the interpolation, and is then emitted, and any result waits
// in the result register on rsp_tready. The distance uses one 32x32 product
// a cycle. Results leave through a single output register. The closing edge
// is clipped with the last-marked vertex (or the one that fills MAX_VERTS),
// and the last result of each polygon carries the end flag and the emitted
// count (a kind-2 terminator when nothing else is left).
module polygon_plane_clip_core #(
   parameter int MAX_VERTS = ppc_pkg::MaxVertsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,  // vertex_x, vertex_y, vertex_z
   input  wire logic         req_tlast,  // last_vertex
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,  // out_x, out_y, out_z, out_count
   output logic [2:0]        rsp_tuser,  // out_kind (2), then pad
   output logic              rsp_tlast,  // polygon_end
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   ppc_pkg::cmd_type    cmd;
   ppc_pkg::status_type st;
   logic idle, start;
   logic [31:0] ox, oy, oz;
   logic [1:0]  okind;
   logic [7:0]  ocnt;

   // hold off input words during reset and while a vertex is worked
   assign req_tready = idle && !reset;
   assign start = req_tvalid && req_tready;

   ppc_ctrl u_ctrl (.clock, .reset, .start, .st, .cmd, .idle);

   ppc_datapath #(.MAX_VERTS(MAX_VERTS)) u_dp (
      .clock, .reset, .cmd, .st, .csr_we, .csr_index, .csr_wdata,
      .in_x(req_tdata[31:0]), .in_y(req_tdata[63:32]), .in_z(req_tdata[95:64]),
      .in_last(req_tlast), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_x(ox), .out_y(oy), .out_z(oz), .out_kind(okind), .out_end(rsp_tlast),
      .out_count(ocnt));

   assign rsp_tdata = {ocnt, oz, oy, ox};
   assign rsp_tuser = {1'b0, okind};
endmodule
`default_nettype wire

### rtl/ppc_ctrl.sv
// Controller state machine for the polygon plane clipper.
`default_nettype none
module ppc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire ppc_pkg::status_type st,
   output ppc_pkg::cmd_type        cmd,
   output logic                    idle
);
   ppc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppc_pkg::ST_IDLE:   if (start) state_in = ppc_pkg::ST_DOT_X;
         ppc_pkg::ST_DOT_X:  state_in = ppc_pkg::ST_DOT_Y;
         ppc_pkg::ST_DOT_Y:  state_in = ppc_pkg::ST_DOT_Z;
         ppc_pkg::ST_DOT_Z:  state_in = ppc_pkg::ST_DIST;
         ppc_pkg::ST_DIST:   state_in = ppc_pkg::ST_EDGE1;
         ppc_pkg::ST_EDGE1: begin
            priority if (st.first) state_in = ppc_pkg::ST_EDGE2;
            else if (st.prev_in != st.cur_in) state_in = ppc_pkg::ST_DIV1;
            else if (st.cur_in) state_in = ppc_pkg::ST_EMIT_K1;
            else state_in = ppc_pkg::ST_EDGE2;
         end
         ppc_pkg::ST_DIV1:   if (st.div_done) state_in = ppc_pkg::ST_MUL1;
         ppc_pkg::ST_MUL1:   if (st.mul_done) state_in = ppc_pkg::ST_EMIT_I1;
         ppc_pkg::ST_EMIT_I1: if (!st.out_busy)
            state_in = st.cur_in ? ppc_pkg::ST_EMIT_K1 : ppc_pkg::ST_EDGE2;
         ppc_pkg::ST_EMIT_K1: if (!st.out_busy) state_in = ppc_pkg::ST_EDGE2;
         ppc_pkg::ST_EDGE2: begin
            // edge2 status: prev_in/cur_in now describe cur->first
            priority if (!st.is_last) state_in = ppc_pkg::ST_COMMIT;
            else if (st.first) state_in = ppc_pkg::ST_TERM;
            else if (st.prev_in != st.cur_in) state_in = ppc_pkg::ST_DIV2;
            else if (st.cur_in) state_in = ppc_pkg::ST_EMIT_K2;
            else state_in = ppc_pkg::ST_TERM;
         end
         ppc_pkg::ST_DIV2:   if (st.div_done) state_in = ppc_pkg::ST_MUL2;
         ppc_pkg::ST_MUL2:   if (st.mul_done) state_in = ppc_pkg::ST_EMIT_I2;
         ppc_pkg::ST_EMIT_I2: if (!st.out_busy)
            state_in = st.cur_in ? ppc_pkg::ST_EMIT_K2 : ppc_pkg::ST_TERM;
         ppc_pkg::ST_EMIT_K2: if (!st.out_busy) state_in = ppc_pkg::ST_TERM;
         ppc_pkg::ST_TERM:   if (!st.out_busy) state_in = ppc_pkg::ST_COMMIT;
         ppc_pkg::ST_COMMIT: state_in = ppc_pkg::ST_IDLE;
         default:            state_in = ppc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.op = ppc_pkg::OP_NONE;
      cmd.edge2 = 1'b0;
      unique case (state_ff)
         ppc_pkg::ST_IDLE:   if (start) cmd.op = ppc_pkg::OP_CAPTURE;
         ppc_pkg::ST_DOT_X:  cmd.op = ppc_pkg::OP_DOT_X;
         ppc_pkg::ST_DOT_Y:  cmd.op = ppc_pkg::OP_DOT_Y;
         ppc_pkg::ST_DOT_Z:  cmd.op = ppc_pkg::OP_DOT_Z;
         ppc_pkg::ST_DIST:   cmd.op = ppc_pkg::OP_DIST;
         ppc_pkg::ST_EDGE1:  cmd.op = ppc_pkg::OP_DIV_START;
         ppc_pkg::ST_DIV1:   cmd.op = ppc_pkg::OP_DIV_STEP;
         ppc_pkg::ST_MUL1:   cmd.op = ppc_pkg::OP_MUL;
         ppc_pkg::ST_EMIT_I1: begin
            cmd.emit = 1'b1; cmd.kind = ppc_pkg::KIND_ISECT;
            cmd.emit_end = st.is_last && !st.cur_in && st.end_pending;
         end
         ppc_pkg::ST_EMIT_K1: begin
            cmd.emit = 1'b1; cmd.kind = ppc_pkg::KIND_KEPT;
            cmd.emit_end = st.is_last && st.end_pending;
         end
         ppc_pkg::ST_EDGE2: begin cmd.edge2 = 1'b1; cmd.op = ppc_pkg::OP_DIV_START; end
         ppc_pkg::ST_DIV2:  begin cmd.edge2 = 1'b1; cmd.op = ppc_pkg::OP_DIV_STEP; end
         ppc_pkg::ST_MUL2:  begin cmd.edge2 = 1'b1; cmd.op = ppc_pkg::OP_MUL; end
         ppc_pkg::ST_EMIT_I2: begin
            cmd.edge2 = 1'b1; cmd.emit = 1'b1; cmd.kind = ppc_pkg::KIND_ISECT;
            cmd.emit_end = !st.cur_in;
         end
         ppc_pkg::ST_EMIT_K2: begin
            cmd.edge2 = 1'b1; cmd.emit = 1'b1; cmd.kind = ppc_pkg::KIND_KEPT;
            cmd.emit_end = 1'b1;
         end
         ppc_pkg::ST_TERM: begin
            cmd.edge2 = 1'b1; cmd.emit = st.end_pending; cmd.kind = ppc_pkg::KIND_TERM;
            cmd.emit_end = 1'b1;
         end
         ppc_pkg::ST_COMMIT: cmd.op = ppc_pkg::OP_COMMIT;
         default: cmd.op = ppc_pkg::OP_NONE;
      endcase
   end

   assign idle = (state_ff == ppc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ppc_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ppc_pkg::ST_IDLE) else $error("start while busy");
   a_capture: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppc_pkg::ST_IDLE && start) |=> state_ff == ppc_pkg::ST_DOT_X)
      else $error("capture not followed by dot");
   a_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ppc_pkg::ST_COMMIT |=> state_ff == ppc_pkg::ST_IDLE)
      else $error("commit did not return");
`endif
endmodule
`default_nettype wire

### rtl/ppc_datapath.sv
// Datapath: distance, divider, interpolation, vertex state and result register.
`default_nettype none
module ppc_datapath #(
   parameter int MAX_VERTS = ppc_pkg::MaxVertsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ppc_pkg::cmd_type  cmd,
   output ppc_pkg::status_type    st,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata,
   input  wire logic [31:0]       in_x,
   input  wire logic [31:0]       in_y,
   input  wire logic [31:0]       in_z,
   input  wire logic              in_last,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [31:0]            out_x,
   output logic [31:0]            out_y,
   output logic [31:0]            out_z,
   output logic [1:0]             out_kind,
   output logic                   out_end,
   output logic [7:0]             out_count
);
   localparam int SeenW = $clog2(MAX_VERTS + 1);
   localparam int TWm1 = ppc_pkg::TW - 1;

   logic signed [31:0] nx_ff, ny_ff, nz_ff, ofs_ff;
   logic signed [31:0] cur_ff [3];
   logic signed [31:0] first_ff [3];
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] cd_ff, fd_ff, pd_ff;
   logic               last_ff;
   logic [SeenW-1:0]   seen_ff;
   logic [7:0]         emitted_ff;
   logic signed [49:0] acc_ff;
   logic signed [47:0] prod_ff;
   // divider
   logic [32:0]        num_ff, den_ff;
   logic [33:0]        rem_ff;
   logic [TWm1:0]      q_ff;
   logic [4:0]         dcnt_ff;
   logic               div_done_ff;
   logic [1:0]         mcnt_ff;
   logic               mul_done_ff;
   logic signed [31:0] isect_ff [3];
   logic               emitted_any_ff;

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff <= '0; ny_ff <= '0; nz_ff <= '0; ofs_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ppc_pkg::CSR_NX:  nx_ff  <= csr_wdata;
            ppc_pkg::CSR_NY:  ny_ff  <= csr_wdata;
            ppc_pkg::CSR_NZ:  nz_ff  <= csr_wdata;
            ppc_pkg::CSR_OFS: ofs_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // edge operands
   logic signed [31:0] ep [3];
   logic signed [31:0] ec [3];
   logic signed [31:0] epd, ecd;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ep[i] = cmd.edge2 ? cur_ff[i] : prev_ff[i];
         ec[i] = cmd.edge2 ? first_ff[i] : cur_ff[i];
      end
      epd = cmd.edge2 ? cd_ff : pd_ff;
      ecd = cmd.edge2 ? fd_ff : cd_ff;
   end

   logic is_first, is_last_eff;
   assign is_first = (seen_ff == '0);
   assign is_last_eff = last_ff || ({1'b0, seen_ff} + 1'b1 >= (SeenW+1)'(MAX_VERTS));

   // one product per cycle: multiplier input selection
   logic signed [31:0] ma, mb;
   logic signed [63:0] mp;
   logic [1:0] axis;
   always_comb begin
      axis = mcnt_ff;
      ma = nx_ff; mb = cur_ff[0];
      unique case (cmd.op)
         ppc_pkg::OP_DOT_Y: begin ma = ny_ff; mb = cur_ff[1]; end
         ppc_pkg::OP_DOT_Z: begin ma = nz_ff; mb = cur_ff[2]; end
         default: ;
      endcase
      mp = ma * mb;
   end
   // difference may need 33 bits; do it exactly in a separate product
   logic signed [32:0] diff;
   logic signed [50:0] dprod;
   always_comb begin
      diff  = 33'(ec[axis]) - 33'(ep[axis]);
      dprod = diff * $signed({1'b0, q_ff});
   end

   // saturated distance, last product folded in
   logic signed [49:0] acc_sum;
   logic signed [31:0] dist_sat;
   always_comb begin
      acc_sum = acc_ff + 50'(prod_ff);
      if (acc_sum > 50'sd2147483647) dist_sat = 32'h7fffffff;
      else if (acc_sum < -50'sd2147483648) dist_sat = 32'h80000000;
      else dist_sat = acc_sum[31:0];
   end

   // divider step (restoring, radix 2)
   logic [33:0] trial;
   assign trial = {rem_ff[32:0], 1'b0} - {1'b0, den_ff};

   logic [7:0] emit_cnt;
   assign emit_cnt = (emitted_ff == 8'd255) ? emitted_ff : emitted_ff + 8'd1;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ppc_pkg::OP_CAPTURE: begin
            cur_ff[0] <= in_x; cur_ff[1] <= in_y; cur_ff[2] <= in_z;
            last_ff <= in_last;
            acc_ff <= 50'(ofs_ff);
         end
         ppc_pkg::OP_DOT_X: prod_ff <= 48'(mp >>> 16);
         ppc_pkg::OP_DOT_Y, ppc_pkg::OP_DOT_Z: begin
            prod_ff <= 48'(mp >>> 16);
            acc_ff <= acc_sum;
         end
         ppc_pkg::OP_DIST: cd_ff <= dist_sat;
         ppc_pkg::OP_DIV_START: begin
            num_ff <= epd[31] ? 33'(-34'(epd)) : 33'(epd);
            den_ff <= (34'(epd) - 34'(ecd)) < 0 ? 33'(34'(ecd) - 34'(epd))
                                                 : 33'(34'(epd) - 34'(ecd));
            rem_ff <= '0; q_ff <= '0; dcnt_ff <= '0; mcnt_ff <= '0;
            div_done_ff <= 1'b0; mul_done_ff <= 1'b0;
         end
         ppc_pkg::OP_DIV_STEP: begin
            // load, integer bit, then 16 fraction bits; hold once done
            if (div_done_ff) begin
            end else if (dcnt_ff == 5'd0 && rem_ff == '0 && num_ff != '0) begin
               // load: remainder starts as numerator; quotient from fraction
               rem_ff <= {1'b0, num_ff};
               dcnt_ff <= 5'd1;
            end else if (den_ff == '0) begin
               q_ff <= '0; div_done_ff <= 1'b1;
            end else if (dcnt_ff == 5'd0) begin
               q_ff <= '0; div_done_ff <= 1'b1;
            end else begin
               // num <= den always, so integer part is 0 or 1
               if (dcnt_ff == 5'd1) begin
                  if (rem_ff >= {1'b0, den_ff}) begin
                     q_ff <= 17'h10000; div_done_ff <= 1'b1;
                  end
                  dcnt_ff <= 5'd2;
               end else begin
                  if (!trial[33]) begin
                     rem_ff <= trial; q_ff <= {q_ff[15:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[32:0], 1'b0}; q_ff <= {q_ff[15:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 5'd1;
                  if (dcnt_ff == 5'd17) div_done_ff <= 1'b1;
               end
            end
         end
         ppc_pkg::OP_MUL: begin
            if (!mul_done_ff) begin
               isect_ff[axis] <= 32'(ep[axis] + 32'(dprod >>> 16));
               if (mcnt_ff == 2'd2) mul_done_ff <= 1'b1;
               else mcnt_ff <= mcnt_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // polygon state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0; emitted_ff <= '0; out_valid <= 1'b0; emitted_any_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            first_ff[i] <= '0; prev_ff[i] <= '0;
         end
         fd_ff <= '0; pd_ff <= '0;
      end else begin
         if (cmd.emit && !(out_valid && !out_ready)) begin
            out_valid <= 1'b1;
            out_kind  <= cmd.kind;
            out_end   <= cmd.emit_end;
            if (cmd.kind == ppc_pkg::KIND_TERM) begin
               out_x <= '0; out_y <= '0; out_z <= '0;
               out_count <= cmd.emit_end ? emitted_ff : 8'd0;
            end else begin
               out_x <= (cmd.kind == ppc_pkg::KIND_KEPT) ? ec[0] : isect_ff[0];
               out_y <= (cmd.kind == ppc_pkg::KIND_KEPT) ? ec[1] : isect_ff[1];
               out_z <= (cmd.kind == ppc_pkg::KIND_KEPT) ? ec[2] : isect_ff[2];
               out_count <= cmd.emit_end ? emit_cnt : 8'd0;
               emitted_ff <= emit_cnt;
               emitted_any_ff <= 1'b1;
            end
         end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
         end
         if (cmd.op == ppc_pkg::OP_COMMIT) begin
            if (is_first) begin
               for (int i = 0; i < 3; i++) first_ff[i] <= cur_ff[i];
               fd_ff <= cd_ff;
            end
            for (int i = 0; i < 3; i++) prev_ff[i] <= cur_ff[i];
            pd_ff <= cd_ff;
            emitted_any_ff <= 1'b0;
            if (is_last_eff) begin
               seen_ff <= '0; emitted_ff <= '0;
            end else begin
               seen_ff <= seen_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      st.prev_in = cmd.edge2 ? cd_ff[31] : pd_ff[31];
      st.cur_in  = cmd.edge2 ? fd_ff[31] : cd_ff[31];
      st.div_done = div_done_ff;
      st.mul_done = mul_done_ff;
      st.is_last = is_last_eff;
      st.first = is_first;
      st.out_busy = out_valid && !out_ready;
      // end_pending: on edge1, the closing edge emits nothing; on term, nothing emitted yet
      st.end_pending = cmd.edge2 ? !emitted_any_ff
                                 : (is_first || (cd_ff[31] == fd_ff[31] && !fd_ff[31]));
   end

`ifndef NO_ASSERTIONS
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_kind == ppc_pkg::KIND_KEPT || out_kind == ppc_pkg::KIND_ISECT ||
                     out_kind == ppc_pkg::KIND_TERM)) else $error("bad kind");
   a_term_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_kind == ppc_pkg::KIND_TERM) |-> out_end)
      else $error("terminator without end");
`endif
endmodule
`default_nettype wire
